// File: rtl/core/tbsfb_pkg.sv
// ----------------------------------------------------------------------------
// Two-band split 5x5 filter bank: shared package
// Types, widths, register indexes and folded filter coefficients used by the
// filter bank core.
// ----------------------------------------------------------------------------
package tbsfb_pkg;

    // Sample and line store geometry.
    localparam int SAMPLE_W = 16;
    localparam int TAPS     = 5;
    localparam int LINES    = 4;
    localparam int STORE_W  = LINES * SAMPLE_W;

    // Configuration registers.
    localparam int LW_W    = 11;
    localparam int VIS_W   = 16;
    localparam int CFG_A_W = 1;
    localparam int CFG_D_W = 16;

    localparam logic [CFG_A_W-1:0] REG_LINE_WIDTH = 1'd0;
    localparam logic [CFG_A_W-1:0] REG_VISIBILITY = 1'd1;

    localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 11'd1024;
    localparam logic [VIS_W-1:0] VISIBILITY_RST = 16'd4096;

    // Band order inside the result word.
    localparam int NBANDS  = 4;
    localparam int BAND_LL = 0;
    localparam int BAND_LH = 1;
    localparam int BAND_HL = 2;
    localparam int BAND_HH = 3;
    localparam int BAND_W  = 32;

    // Arithmetic widths: window sums, Q30 accumulator, Q16, gain product.
    localparam int SUM_W   = 21;
    localparam int COEF_W  = 30;
    localparam int ACC_W   = 50;
    localparam int Q16_SH  = 14;
    localparam int Q16_W   = ACC_W - Q16_SH;
    localparam int PROD_W  = Q16_W + VIS_W + 1;
    localparam int Q8_SH   = 20;
    localparam int Q8_W    = PROD_W - Q8_SH;

    // Products of the Q1.15 taps. Low tap is 6554, high outer tap 18919,
    // high inner tap 13378.
    localparam logic signed [COEF_W-1:0] K_LL   = 30'sd42954916;  // low * low
    localparam logic signed [COEF_W-1:0] K_LO_A = 30'sd123995126; // low * outer
    localparam logic signed [COEF_W-1:0] K_LO_B = 30'sd87679412;  // low * inner
    localparam logic signed [COEF_W-1:0] K_AA   = 30'sd357928561; // outer * outer
    localparam logic signed [COEF_W-1:0] K_AB   = 30'sd253098382; // outer * inner
    localparam logic signed [COEF_W-1:0] K_BB   = 30'sd178970884; // inner * inner

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    wsum_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [Q16_W-1:0]    q16_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [BAND_W-1:0]   band_t;

endpackage

// File: rtl/core/two_band_split_5x5_filter_bank_core.sv
// ----------------------------------------------------------------------------
// Two-band split 5x5 filter bank core
// Separable 5x5 FIR over a raster sample stream, four bands (LL, LH, HL, HH)
// with visibility gain, rounding and saturation.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents
//  s_*       in         tdata: sample; tuser: start_of_frame
//  m_*       out        tdata: band_ll, band_lh, band_hl, band_hh; tlast: row_end
//  cfg_*     in         write only: 0 = line_width, 1 = visibility
//
//  One word is accepted per clock while s_tready is high. A result reaches
//  the output register through the line store read, window shift, window
//  sums, coefficient products, Q16 rounding, gain product and final
//  rounding, each in a separate stage.
//  The line store is a single-port-write, registered-read memory of
//  MAX_LINE words of four samples; a read of the column just written is
//  forwarded. Each stage holds when the stage after it is full and stalled,
//  so input keeps flowing into empty stages while the output waits.
//  Reset is synchronous and active low; it clears valid bits and counters and
//  loads the configuration reset values. The line store is not cleared.
//
module two_band_split_5x5_filter_bank_core
    import tbsfb_pkg::*;
#(
    parameter int MAX_LINE = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [CFG_A_W-1:0]          cfg_addr,
    input  logic [CFG_D_W-1:0]          cfg_wdata,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [SAMPLE_W-1:0]         s_tdata,   // [15:0] sample
    input  logic [0:0]                  s_tuser,   // [0] start_of_frame

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [NBANDS*BAND_W-1:0]    m_tdata,   // [31:0] ll, [63:32] lh,
                                                   // [95:64] hl, [127:96] hh
    output logic                        m_tlast    // row_end
);

    localparam int CW   = $clog2(MAX_LINE);
    localparam int WW_A = $clog2(MAX_LINE + 1);
    localparam int WW   = (LW_W > WW_A) ? LW_W : WW_A;

    localparam logic [WW-1:0] W_MIN  = WW'(6);
    localparam logic [WW-1:0] W_MAX  = WW'(MAX_LINE);
    localparam logic [WW-1:0] C_MIN  = WW'(TAPS - 1);
    localparam logic [2:0]    ROWS_FULL = 3'(LINES);

    // ------------------------------------------------------------------
    // Configuration registers.
    logic [LW_W-1:0]  line_width_reg;
    logic [VIS_W-1:0] visibility_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_WIDTH_RST;
            visibility_reg <= VISIBILITY_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LINE_WIDTH: line_width_reg <= cfg_wdata[LW_W-1:0];
                REG_VISIBILITY: visibility_reg <= cfg_wdata[VIS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or its content moves on.
    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg, m_v_reg;
    logic en_a, en_b, en_c, en_d, en_e, en_f, en_g;
    logic s_acc, a_adv;

    assign en_g     = !m_v_reg || m_tready;
    assign en_f     = !f_v_reg || en_g;
    assign en_e     = !e_v_reg || en_f;
    assign en_d     = !d_v_reg || en_e;
    assign en_c     = !c_v_reg || en_d;
    assign en_b     = !b_v_reg || en_c;
    assign en_a     = !a_v_reg || en_b;
    assign s_tready = en_a;
    assign s_acc    = s_tvalid && en_a;
    assign a_adv    = a_v_reg && en_b;

    // ------------------------------------------------------------------
    // Column and line counting at the accepting edge.
    logic [CW-1:0] column_count_reg, column_count_next;
    logic [2:0]    rows_seen_reg, rows_seen_next;
    logic [CW-1:0] c_cur;
    logic [2:0]    rows_cur;
    logic [WW-1:0] lw_ext, w_eff, c_ext;
    logic          col_wrap, emit_cur, last_cur;

    always_comb begin
        lw_ext = WW'(line_width_reg);
        if (lw_ext < W_MIN) begin
            w_eff = W_MIN;
        end else if (lw_ext > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = lw_ext;
        end
        c_cur    = s_tuser[0] ? '0 : column_count_reg;
        rows_cur = s_tuser[0] ? '0 : rows_seen_reg;
        c_ext    = WW'(c_cur);
        col_wrap = c_ext >= (w_eff - WW'(1));
        last_cur = c_ext == (w_eff - WW'(2));
        emit_cur = (rows_cur == ROWS_FULL) && (c_ext >= C_MIN)
                   && (c_ext <= (w_eff - WW'(2)));
        if (col_wrap) begin
            column_count_next = '0;
            rows_seen_next    = (rows_cur < ROWS_FULL) ? rows_cur + 3'd1 : rows_cur;
        end else begin
            column_count_next = c_cur + CW'(1);
            rows_seen_next    = rows_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            rows_seen_reg    <= '0;
        end else if (s_acc) begin
            column_count_reg <= column_count_next;
            rows_seen_reg    <= rows_seen_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: line store read, with forwarding of a same-column write.
    logic [STORE_W-1:0] mem [MAX_LINE];
    logic [STORE_W-1:0] rd_reg, fwd_data_reg, old_col, new_store;
    logic [CW-1:0]      a_addr_reg;
    sample_t            a_sample_reg;
    logic               a_emit_reg, a_last_reg, a_fwd_reg;

    assign old_col   = a_fwd_reg ? fwd_data_reg : rd_reg;
    // Lines move up by one; the new sample becomes the newest stored line.
    assign new_store = {a_sample_reg, old_col[STORE_W-1:SAMPLE_W]};

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            rd_reg <= mem[c_cur];
        end
        if (a_adv) begin
            mem[a_addr_reg] <= new_store;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (en_a) begin
            a_v_reg <= s_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            a_addr_reg   <= c_cur;
            a_sample_reg <= s_tdata;
            a_emit_reg   <= emit_cur;
            a_last_reg   <= last_cur;
            a_fwd_reg    <= a_adv && (a_addr_reg == c_cur);
            fwd_data_reg <= new_store;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: 5x5 window, shifted left by one column per word.
    sample_t win_reg [TAPS][TAPS];
    logic    b_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (en_b) begin
            b_v_reg <= a_v_reg && a_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv) begin
            for (int i = 0; i < TAPS; i++) begin
                for (int j = 0; j < TAPS - 1; j++) begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
            end
            for (int i = 0; i < LINES; i++) begin
                win_reg[i][TAPS-1] <= old_col[i*SAMPLE_W +: SAMPLE_W];
            end
            win_reg[TAPS-1][TAPS-1] <= a_sample_reg;
            b_last_reg <= a_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: window sums. The low taps are equal and the high taps antisymmetric, so
    // each band reduces to a few sums and differences times folded coefficients.
    wsum_t row_sum [TAPS];
    wsum_t s_all, d_out, d_in, r_out, r_in, h_aa, h_ab, h_bb;
    wsum_t c_s_reg, c_dout_reg, c_din_reg, c_rout_reg, c_rin_reg;
    wsum_t c_haa_reg, c_hab_reg, c_hbb_reg;
    logic  c_last_reg;

    always_comb begin
        s_all = '0;
        d_out = '0;
        d_in  = '0;
        for (int i = 0; i < TAPS; i++) begin
            row_sum[i] = '0;
            for (int j = 0; j < TAPS; j++) begin
                row_sum[i] = row_sum[i] + SUM_W'(win_reg[i][j]);
            end
            s_all = s_all + row_sum[i];
            d_out = d_out + SUM_W'(win_reg[i][4]) - SUM_W'(win_reg[i][0]);
            d_in  = d_in + SUM_W'(win_reg[i][3]) - SUM_W'(win_reg[i][1]);
        end
        r_out = row_sum[4] - row_sum[0];
        r_in  = row_sum[3] - row_sum[1];
        h_aa  = SUM_W'(win_reg[0][0]) - SUM_W'(win_reg[0][4])
              - SUM_W'(win_reg[4][0]) + SUM_W'(win_reg[4][4]);
        h_ab  = SUM_W'(win_reg[0][1]) - SUM_W'(win_reg[0][3])
              - SUM_W'(win_reg[4][1]) + SUM_W'(win_reg[4][3])
              + SUM_W'(win_reg[1][0]) - SUM_W'(win_reg[3][0])
              - SUM_W'(win_reg[1][4]) + SUM_W'(win_reg[3][4]);
        h_bb  = SUM_W'(win_reg[1][1]) - SUM_W'(win_reg[1][3])
              - SUM_W'(win_reg[3][1]) + SUM_W'(win_reg[3][3]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
        end else if (en_c) begin
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c && b_v_reg) begin
            c_s_reg    <= s_all;
            c_dout_reg <= d_out;
            c_din_reg  <= d_in;
            c_rout_reg <= r_out;
            c_rin_reg  <= r_in;
            c_haa_reg  <= h_aa;
            c_hab_reg  <= h_ab;
            c_hbb_reg  <= h_bb;
            c_last_reg <= b_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: products with the folded coefficients, exact in Q30.
    acc_t d_ll_reg, d_lh_a_reg, d_lh_b_reg, d_hl_a_reg, d_hl_b_reg;
    acc_t d_hh_a_reg, d_hh_b_reg, d_hh_c_reg;
    logic d_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg <= 1'b0;
        end else if (en_d) begin
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_d && c_v_reg) begin
            d_ll_reg   <= ACC_W'(c_s_reg)    * ACC_W'(K_LL);
            d_lh_a_reg <= ACC_W'(c_dout_reg) * ACC_W'(K_LO_A);
            d_lh_b_reg <= ACC_W'(c_din_reg)  * ACC_W'(K_LO_B);
            d_hl_a_reg <= ACC_W'(c_rout_reg) * ACC_W'(K_LO_A);
            d_hl_b_reg <= ACC_W'(c_rin_reg)  * ACC_W'(K_LO_B);
            d_hh_a_reg <= ACC_W'(c_haa_reg)  * ACC_W'(K_AA);
            d_hh_b_reg <= ACC_W'(c_hab_reg)  * ACC_W'(K_AB);
            d_hh_c_reg <= ACC_W'(c_hbb_reg)  * ACC_W'(K_BB);
            d_last_reg <= c_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: band sums, rounded half up from Q30 to Q16.
    localparam acc_t RND_Q16 = ACC_W'(1) <<< (Q16_SH - 1);

    acc_t acc_band [NBANDS];
    q16_t e_q16_reg [NBANDS];
    logic e_last_reg;

    always_comb begin
        acc_band[BAND_LL] = d_ll_reg + RND_Q16;
        acc_band[BAND_LH] = d_lh_a_reg + d_lh_b_reg + RND_Q16;
        acc_band[BAND_HL] = d_hl_a_reg + d_hl_b_reg + RND_Q16;
        acc_band[BAND_HH] = d_hh_a_reg + d_hh_b_reg + d_hh_c_reg + RND_Q16;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_v_reg <= 1'b0;
        end else if (en_e) begin
            e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_e && d_v_reg) begin
            for (int b = 0; b < NBANDS; b++) begin
                e_q16_reg[b] <= acc_band[b][ACC_W-1:Q16_SH];
            end
            e_last_reg <= d_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage F: visibility gain, Q16 times Q4.12 gives Q28.
    prod_t f_prod_reg [NBANDS];
    prod_t vis_ext;
    logic  f_last_reg;

    assign vis_ext = PROD_W'({1'b0, visibility_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_v_reg <= 1'b0;
        end else if (en_f) begin
            f_v_reg <= e_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_f && e_v_reg) begin
            for (int b = 0; b < NBANDS; b++) begin
                f_prod_reg[b] <= PROD_W'(e_q16_reg[b]) * vis_ext;
            end
            f_last_reg <= e_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: round half up to Q8 and saturate to 32 bits.
    localparam prod_t RND_Q8 = PROD_W'(1) <<< (Q8_SH - 1);

    logic signed [Q8_W-1:0] q8 [NBANDS];
    band_t                  band_sat [NBANDS];
    band_t                  m_band_reg [NBANDS];
    logic                   m_last_reg;
    prod_t                  prod_rnd [NBANDS];

    always_comb begin
        for (int b = 0; b < NBANDS; b++) begin
            prod_rnd[b] = f_prod_reg[b] + RND_Q8;
            q8[b]       = prod_rnd[b][PROD_W-1:Q8_SH];
            // Out of range when the bits above the result are not all sign.
            if (q8[b][Q8_W-1:BAND_W-1] != {(Q8_W-BAND_W+1){q8[b][Q8_W-1]}}) begin
                band_sat[b] = q8[b][Q8_W-1] ? {1'b1, {(BAND_W-1){1'b0}}}
                                            : {1'b0, {(BAND_W-1){1'b1}}};
            end else begin
                band_sat[b] = q8[b][BAND_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg <= 1'b0;
        end else if (en_g) begin
            m_v_reg <= f_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_g && f_v_reg) begin
            for (int b = 0; b < NBANDS; b++) begin
                m_band_reg[b] <= band_sat[b];
            end
            m_last_reg <= f_last_reg;
        end
    end

    // Output word.
    assign m_tvalid = m_v_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {m_band_reg[BAND_HH], m_band_reg[BAND_HL],
                       m_band_reg[BAND_LH], m_band_reg[BAND_LL]};

endmodule
